>>> hw/rtl/halton_sequence_generator_unit_macros.svh
// assertion helpers for the halton sequence generator
`ifndef HALTON_SEQUENCE_GENERATOR_UNIT_MACROS_SVH
`define HALTON_SEQUENCE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hsg_pkg.sv
package hsg_pkg;

    localparam int MAX_DIGITS_DEF  = 32;
    localparam int INDEX_BITS_DEF  = 32;
    localparam int PRIME_COUNT_DEF = 100;

    localparam int PRIME_ROM_SIZE  = 100;
    localparam int LAST_PRIME_POS  = 99;
    localparam int LARGEST_PRIME   = 541;
    localparam int DIGIT_BITS      = $clog2(LARGEST_PRIME + 1);
    localparam int BASE_IDX_BITS   = 7;
    localparam int FRAC_BITS       = 32;
    localparam int REG_DATA_BITS   = 32;
    localparam int REG_ADDR_BITS   = 3;

    // register map, one word per register
    localparam int REG_BASE_INDEX  = 0;

    // long division of 2^32 (then of each previous quotient) by the prime, one quotient bit per step
    localparam int DIV_STEPS       = FRAC_BITS + 1;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);

    typedef logic [DIGIT_BITS-1:0] t_digit;

    typedef enum logic [4:0] {
        S_START  = 5'b00001,
        S_DIV    = 5'b00010,
        S_WSTORE = 5'b00100,
        S_IDLE   = 5'b01000,
        S_RIPPLE = 5'b10000
    } t_state;

    localparam t_digit PRIME_ROM [0:PRIME_ROM_SIZE-1] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,
        10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,
        10'd73,  10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
        10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229,
        10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281,
        10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349,
        10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463,
        10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541
    };

endpackage

>>> hw/rtl/halton_sequence_generator_unit.sv
// One dimension of the Halton sequence: each input transaction advances a running index by one
// and, when its emit flag is set, first returns the radical inverse of the current index in the
// selected prime base as a Q0.32 fraction together with the index. The base-p digits live in a
// digit memory and the per-digit weights floor(2^32/p^(k+1)), with the matching (p-1)*weight
// correction, in a weight memory. A point is accepted, then digit 0 gets one read-modify-write,
// and the carry ripples through every trailing digit equal to p-1, each carried digit being one
// memory read; the item on which the index wraps clears digits and fraction with no ripple.
// Up to two results queue at the output. After reset and after every write of base_index the
// weights are rebuilt by a bit-serial divider, with s_axis tready low meanwhile. base_index
// values whose low 7 bits are at or above PRIME_COUNT select the last prime.
`include "halton_sequence_generator_unit_macros.svh"

module halton_sequence_generator_unit #(
    parameter int MAX_DIGITS  = hsg_pkg::MAX_DIGITS_DEF,
    parameter int INDEX_BITS  = hsg_pkg::INDEX_BITS_DEF,
    parameter int PRIME_COUNT = hsg_pkg::PRIME_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // [0] emit_value, rest zero
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [63:0]                       o_m_axis_tdata,   // [31:0] fraction, [63:32] point_index
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hsg_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [hsg_pkg::REG_DATA_BITS-1:0] pwdata,
    output logic [hsg_pkg::REG_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam logic [AW-1:0] LAST_DIGIT = AW'(MAX_DIGITS - 1);
    localparam logic [hsg_pkg::BASE_IDX_BITS-1:0] BASE_LIMIT = 
        hsg_pkg::BASE_IDX_BITS'(PRIME_COUNT);
    localparam logic [hsg_pkg::BASE_IDX_BITS-1:0] BASE_TOP =
        hsg_pkg::BASE_IDX_BITS'(PRIME_COUNT - 1);
    localparam logic [hsg_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
        hsg_pkg::DIV_CNT_BITS'(hsg_pkg::DIV_STEPS - 1);
    localparam int FB = hsg_pkg::FRAC_BITS;
    localparam int DB = hsg_pkg::DIGIT_BITS;

    hsg_pkg::t_state                  r_state, n_state;
    logic [hsg_pkg::BASE_IDX_BITS-1:0] r_base, n_base;
    logic [INDEX_BITS-1:0]            r_index, n_index;
    logic [FB-1:0]                    r_frac, n_frac;
    logic [MAX_DIGITS-1:0]            r_dvalid, n_dvalid;

    hsg_pkg::t_digit                  r_prime, n_prime;
    logic [FB:0]                      r_num, n_num;
    hsg_pkg::t_digit                  r_rem, n_rem;
    logic [hsg_pkg::DIV_CNT_BITS-1:0] r_dcnt, n_dcnt;
    logic [AW-1:0]                    r_k, n_k;
    logic [AW-1:0]                    r_j, n_j;

    // digit memory and weight memory ({(p-1)*weight, weight})
    hsg_pkg::t_digit                  r_dmem [MAX_DIGITS];
    logic [2*FB-1:0]                  r_wmem [MAX_DIGITS];
    hsg_pkg::t_digit                  r_drd;
    logic [2*FB-1:0]                  r_wrd;

    logic [63:0]                      r_q [2];
    logic [1:0]                       r_qcnt;

    logic                             w_cfg_wr;
    logic [hsg_pkg::BASE_IDX_BITS-1:0] w_wbase;
    logic                             w_in_acc;
    logic                             w_pop;
    logic                             w_push;
    logic                             w_dwe;
    logic                             w_wwe;
    logic [AW-1:0]                    w_raddr;
    logic [DB:0]                      w_trial;
    logic                             w_ge;
    logic [FB+DB-1:0]                 w_negfull;
    hsg_pkg::t_digit                  w_dcur;
    hsg_pkg::t_digit                  w_dinc;
    logic [63:0]                      w_idx_wide;
    logic [63:0]                      w_result;

    assign pready   = 1'b1;
    assign prdata   = {(hsg_pkg::REG_DATA_BITS - hsg_pkg::BASE_IDX_BITS)'(0), r_base};
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[hsg_pkg::REG_ADDR_BITS-1] == 1'(hsg_pkg::REG_BASE_INDEX));
    assign w_wbase  = (pwdata[hsg_pkg::BASE_IDX_BITS-1:0] >= BASE_LIMIT) ? BASE_TOP
                    : pwdata[hsg_pkg::BASE_IDX_BITS-1:0];

    assign o_s_axis_tready = (r_state == hsg_pkg::S_IDLE) && (r_qcnt != 2'd2);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_qcnt != 2'd0);
    assign o_m_axis_tdata  = r_q[0];
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;

    assign w_idx_wide = 64'(r_index);
    assign w_result   = {w_idx_wide[31:0], r_frac};

    // restoring division step
    assign w_trial   = {r_rem, r_num[FB]};
    assign w_ge      = (w_trial >= {1'b0, r_prime});
    assign w_negfull = {{FB{1'b0}}, r_prime - DB'(1)} * {{DB{1'b0}}, r_num[FB-1:0]};

    assign w_dcur = r_dvalid[r_j] ? r_drd : '0;
    assign w_dinc = w_dcur + DB'(1);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_index  = r_index;
        n_frac   = r_frac;
        n_dvalid = r_dvalid;
        n_prime  = r_prime;
        n_num    = r_num;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_k      = r_k;
        n_j      = r_j;
        w_push   = 1'b0;
        w_dwe    = 1'b0;
        w_wwe    = 1'b0;
        w_raddr  = '0;
        unique case (r_state)
            hsg_pkg::S_START: begin
                n_prime = hsg_pkg::PRIME_ROM[r_base];
                n_num   = {1'b1, {FB{1'b0}}};
                n_rem   = '0;
                n_dcnt  = '0;
                n_k     = '0;
                n_state = hsg_pkg::S_DIV;
            end
            hsg_pkg::S_DIV: begin
                n_rem  = w_ge ? DB'(w_trial - {1'b0, r_prime}) : DB'(w_trial);
                n_num  = {r_num[FB-1:0], w_ge};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DIV_LAST) begin
                    n_state = hsg_pkg::S_WSTORE;
                end
            end
            hsg_pkg::S_WSTORE: begin
                w_wwe = 1'b1;
                if (r_k == LAST_DIGIT) begin
                    n_state = hsg_pkg::S_IDLE;
                end else begin
                    // next weight divides the previous quotient again
                    n_k     = r_k + 1'b1;
                    n_num   = {1'b0, r_num[FB-1:0]};
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = hsg_pkg::S_DIV;
                end
            end
            hsg_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_push  = i_s_axis_tdata[0];
                    n_index = r_index + 1'b1;
                    if (n_index == '0) begin
                        n_dvalid = '0;
                        n_frac   = '0;
                    end else begin
                        n_j     = '0;
                        n_state = hsg_pkg::S_RIPPLE;
                    end
                end
            end
            hsg_pkg::S_RIPPLE: begin
                if (w_dinc < r_prime) begin
                    w_dwe           = 1'b1;
                    n_dvalid[r_j]   = 1'b1;
                    n_frac          = r_frac + r_wrd[FB-1:0];
                    n_state         = hsg_pkg::S_IDLE;
                end else begin
                    // digit rolls over to zero, carry into the next one
                    n_dvalid[r_j]   = 1'b0;
                    n_frac          = r_frac - r_wrd[2*FB-1:FB];
                    if (r_j == LAST_DIGIT) begin
                        n_state = hsg_pkg::S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        w_raddr = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = hsg_pkg::S_START;
            end
        endcase
        if (w_cfg_wr) begin
            n_base   = w_wbase;
            n_state  = hsg_pkg::S_START;
            n_index  = '0;
            n_frac   = '0;
            n_dvalid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsg_pkg::S_START;
            r_base   <= '0;
            r_index  <= '0;
            r_frac   <= '0;
            r_dvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_index  <= n_index;
            r_frac   <= n_frac;
            r_dvalid <= n_dvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prime <= n_prime;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_k     <= n_k;
        r_j     <= n_j;
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            r_dmem[r_j] <= w_dinc;
        end
        r_drd <= r_dmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wwe) begin
            r_wmem[r_k] <= {w_negfull[FB-1:0], r_num[FB-1:0]};
        end
        r_wrd <= r_wmem[w_raddr];
    end

    // two-entry result queue, head in r_q[0]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
        end else begin
            r_qcnt <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q[0] <= (w_push && (r_qcnt == 2'd1)) ? w_result : r_q[1];
            if (w_push && (r_qcnt == 2'd2)) begin
                r_q[1] <= w_result;
            end
        end else if (w_push) begin
            if (r_qcnt == 2'd0) begin
                r_q[0] <= w_result;
            end else begin
                r_q[1] <= w_result;
            end
        end
    end

    `HSG_ASSERT_SAME(a_digit_below_base, i_clk, i_rst_n, (r_state == hsg_pkg::S_RIPPLE) && r_dvalid[r_j], r_drd < r_prime, "stored digit not below the base")
    `HSG_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, r_qcnt != 2'd3, "result queue overflow")
    `HSG_ASSERT_SAME(a_zero_index_zero_frac, i_clk, i_rst_n, r_index == '0, r_frac == '0, "fraction nonzero at index zero")
    `HSG_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, w_push && !w_pop, r_qcnt == $past(r_qcnt) + 2'd1, "queued result not counted")

endmodule
